FILE: rtl/erp_pkg.sv
// ----------------------------------------------------------------------------
// erp_pkg: shared types and constants of the event record parser
// Byte classes, result and error codes, parser phases, queue entry layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package erp_pkg;

   localparam int MAX_RUNES_DEF  = 256;
   localparam int TEXT_BYTES_DEF = 1025;
   localparam int QUEUE_DEPTH    = 2;

   localparam int          NUM_W   = 31;
   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] LEAD_THREE   = 8'hE0;
   localparam logic [7:0] LEAD_FOUR    = 8'hF0;

   typedef enum logic [1:0] {
      KIND_TEXT     = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_ERROR    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_TERMINATOR = 2'd0,
      ERR_NEWLINE    = 2'd1,
      ERR_TOO_LONG   = 2'd2,
      ERR_OVERFLOW   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_ORIGIN,
      PH_TYPE,
      PH_NUM,
      PH_LEAD,
      PH_CONT,
      PH_NEWLINE,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      REC_PRIMARY   = 2'd0,
      REC_EXPANSION = 2'd1,
      REC_DISCARD_A = 2'd2,
      REC_DISCARD_B = 2'd3
   } rec_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_digit;
      logic       is_space;
      logic       is_newline;
   } cmd_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        text_byte;
      logic              from_exp;
      logic [7:0]        origin;
      logic [7:0]        type_char;
      logic [NUM_W-1:0]  start_pos;
      logic [NUM_W-1:0]  end_pos;
      logic [NUM_W-1:0]  exp_start;
      logic [NUM_W-1:0]  exp_end;
      logic [NUM_W-1:0]  flags;
      err_type           err;
   } rsp_base_type;

endpackage

`default_nettype wire

FILE: rtl/editor_event_record_parser.sv
// ----------------------------------------------------------------------------
// editor_event_record_parser: one byte per cycle while the result queue has room.
// Byte queue -> parser -> result queue, 2 entries each; results are registered in the result queue.
// Synchronous reset empties both queues and returns the parser to record start.
// ----------------------------------------------------------------------------
`default_nettype none

module editor_event_record_parser
   import erp_pkg::*;
#(
   parameter int MAX_RUNES  = MAX_RUNES_DEF,
   parameter int TEXT_BYTES = TEXT_BYTES_DEF,
   parameter int RUNE_W     = $clog2(MAX_RUNES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [7:0]        req_in_byte,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic      [1:0]        rsp_result_kind,
   output logic      [7:0]        rsp_text_byte,
   output logic                   rsp_from_expansion,
   output logic      [7:0]        rsp_origin_char,
   output logic      [7:0]        rsp_type_char,
   output logic      [NUM_W-1:0]  rsp_start_pos,
   output logic      [NUM_W-1:0]  rsp_end_pos,
   output logic      [NUM_W-1:0]  rsp_expanded_start,
   output logic      [NUM_W-1:0]  rsp_expanded_end,
   output logic      [NUM_W-1:0]  rsp_flag_bits,
   output logic      [RUNE_W-1:0] rsp_rune_total,
   output logic      [1:0]        rsp_error_code
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_base_type) + RUNE_W;

   cmd_type           front_cmd;
   logic [CMD_W-1:0]  cmd_bits;
   cmd_type           cmd_head;
   logic              cmd_empty;
   logic              cmd_take;
   logic              rsp_full;
   logic              par_push;
   rsp_base_type      par_base;
   logic [RUNE_W-1:0] par_runes;
   logic [RSP_W-1:0]  rsp_bits;
   rsp_base_type      out_base;

   erp_front u_front (
      .in_byte (req_in_byte),
      .cmd     (front_cmd)
   );

   erp_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_take),
      .pop_data  (cmd_bits),
      .empty     (cmd_empty)
   );

   assign cmd_head = cmd_type'(cmd_bits);

   erp_parser #(
      .MAX_RUNES  (MAX_RUNES),
      .TEXT_BYTES (TEXT_BYTES),
      .RUNE_W     (RUNE_W)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_head),
      .cmd_take  (cmd_take),
      .rsp_room  (!rsp_full),
      .rsp_push  (par_push),
      .rsp_base  (par_base),
      .rsp_runes (par_runes)
   );

   erp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (par_push),
      .push_data ({par_base, par_runes}),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign out_base           = rsp_base_type'(rsp_bits[RSP_W-1:RUNE_W]);
   assign rsp_rune_total     = rsp_bits[RUNE_W-1:0];
   assign rsp_result_kind    = out_base.kind;
   assign rsp_text_byte      = out_base.text_byte;
   assign rsp_from_expansion = out_base.from_exp;
   assign rsp_origin_char    = out_base.origin;
   assign rsp_type_char      = out_base.type_char;
   assign rsp_start_pos      = out_base.start_pos;
   assign rsp_end_pos        = out_base.end_pos;
   assign rsp_expanded_start = out_base.exp_start;
   assign rsp_expanded_end   = out_base.exp_end;
   assign rsp_flag_bits      = out_base.flags;
   assign rsp_error_code     = out_base.err;

`ifndef SYNTHESIS
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      par_push |-> (!rsp_full && cmd_take))
      else $error("result transfer without room or byte");

   a_text_no_err : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind != KIND_ERROR) |-> (rsp_error_code == ERR_TERMINATOR))
      else $error("error code set on non-error result");

   a_exp_text_only : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_from_expansion) |-> (rsp_result_kind == KIND_TEXT))
      else $error("expansion mark on non-text result");
`endif

endmodule

`default_nettype wire

FILE: rtl/erp_fifo.sv
// ----------------------------------------------------------------------------
// erp_fifo: small show-ahead queue
// Register-based queue with count-based full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_fifo
   import erp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/erp_front.sv
// ----------------------------------------------------------------------------
// erp_front: byte classifier
// Tags each incoming byte as digit, space or newline for the parser queue.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_front
   import erp_pkg::*;
(
   input  wire logic [7:0] in_byte,
   output cmd_type         cmd
);

   always_comb begin
      cmd.data       = in_byte;
      cmd.is_digit   = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
      cmd.is_space   = (in_byte == CHAR_SPACE);
      cmd.is_newline = (in_byte == CHAR_NEWLINE);
   end

endmodule

`default_nettype wire

FILE: rtl/erp_parser.sv
// ----------------------------------------------------------------------------
// erp_parser: record parser back end
// Walks header, numbers, UTF-8 text and newline; produces result entries.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_parser
   import erp_pkg::*;
#(
   parameter int MAX_RUNES  = MAX_RUNES_DEF,
   parameter int TEXT_BYTES = TEXT_BYTES_DEF,
   parameter int RUNE_W     = $clog2(MAX_RUNES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire cmd_type           cmd,
   output logic                   cmd_take,
   input  wire logic              rsp_room,
   output logic                   rsp_push,
   output rsp_base_type           rsp_base,
   output logic      [RUNE_W-1:0] rsp_runes
);

   localparam int               TB_W     = $clog2(TEXT_BYTES);
   localparam logic [TB_W-1:0]  TB_LIMIT = TB_W'(TEXT_BYTES - 4);
   localparam logic [NUM_W-1:0] RUNE_CAP = NUM_W'(MAX_RUNES);

   phase_type        phase_ff, phase_in;
   rec_type          rec_ff, rec_in;
   logic [1:0]       slot_ff, slot_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [7:0]       origin_ff, origin_in;
   logic [7:0]       type_ff, type_in;
   logic [NUM_W-1:0] start_ff, start_in;
   logic [NUM_W-1:0] end_ff, end_in;
   logic [NUM_W-1:0] exp_start_ff, exp_start_in;
   logic [NUM_W-1:0] exp_end_ff, exp_end_in;
   logic [NUM_W-1:0] flags_ff, flags_in;
   logic [RUNE_W-1:0] runes_ff, runes_in;
   logic [RUNE_W-1:0] left_ff, left_in;
   logic [1:0]       rbl_ff, rbl_in;
   logic [TB_W-1:0]  used_ff, used_in;

   logic [NUM_W+3:0] prod;
   logic [RUNE_W-1:0] clamp_n;
   logic [RUNE_W-1:0] left_dec;
   logic [1:0]       rbl_dec;
   logic             has_rsp;
   logic             err_hit;
   err_type          err_code;
   logic             emit;

   assign cmd_take = cmd_valid && rsp_room;
   assign rsp_push = cmd_take && has_rsp;

   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
               + {(NUM_W)'(0), cmd.data[3:0]};
   assign clamp_n  = (acc_ff > RUNE_CAP) ? RUNE_W'(MAX_RUNES) : acc_ff[RUNE_W-1:0];
   assign left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
   assign rbl_dec  = (rbl_ff != '0) ? rbl_ff - 1'b1 : rbl_ff;

   always_comb begin
      phase_in     = phase_ff;
      rec_in       = rec_ff;
      slot_in      = slot_ff;
      acc_in       = acc_ff;
      origin_in    = origin_ff;
      type_in      = type_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      exp_start_in = exp_start_ff;
      exp_end_in   = exp_end_ff;
      flags_in     = flags_ff;
      runes_in     = runes_ff;
      left_in      = left_ff;
      rbl_in       = rbl_ff;
      used_in      = used_ff;
      err_hit      = 1'b0;
      err_code     = ERR_TERMINATOR;
      emit         = 1'b0;
      has_rsp      = 1'b0;

      rsp_base.kind      = KIND_TEXT;
      rsp_base.text_byte = 8'h00;
      rsp_base.from_exp  = 1'b0;
      rsp_base.origin    = origin_ff;
      rsp_base.type_char = type_ff;
      rsp_base.start_pos = start_ff;
      rsp_base.end_pos   = end_ff;
      rsp_base.exp_start = exp_start_ff;
      rsp_base.exp_end   = exp_end_ff;
      rsp_base.flags     = flags_ff;
      rsp_base.err       = ERR_TERMINATOR;
      rsp_runes          = runes_ff;

      unique case (phase_ff)
         PH_ORIGIN: begin
            if (rec_ff == REC_PRIMARY) begin
               origin_in = cmd.data;
            end
            phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            if (rec_ff == REC_PRIMARY) begin
               type_in = cmd.data;
            end
            acc_in   = '0;
            slot_in  = 2'd0;
            phase_in = PH_NUM;
         end
         PH_NUM: begin
            if (cmd.is_digit) begin
               if (prod > (NUM_W + 4)'(NUM_MAX)) begin
                  err_hit  = 1'b1;
                  err_code = ERR_OVERFLOW;
               end else begin
                  acc_in = prod[NUM_W-1:0];
               end
            end else if (!cmd.is_space) begin
               err_hit  = 1'b1;
               err_code = ERR_TERMINATOR;
            end else begin
               acc_in  = '0;
               slot_in = slot_ff + 1'b1;
               case (slot_ff)
                  2'd0: begin
                     if (rec_ff == REC_PRIMARY) begin
                        start_in     = acc_ff;
                        exp_start_in = acc_ff;
                     end else if (rec_ff == REC_EXPANSION) begin
                        exp_start_in = acc_ff;
                     end
                  end
                  2'd1: begin
                     if (rec_ff == REC_PRIMARY) begin
                        end_in     = acc_ff;
                        exp_end_in = acc_ff;
                     end else if (rec_ff == REC_EXPANSION) begin
                        exp_end_in = acc_ff;
                     end
                  end
                  2'd2: begin
                     if (rec_ff == REC_PRIMARY) begin
                        flags_in = acc_ff;
                     end
                  end
                  default: begin
                     if (rec_ff == REC_PRIMARY) begin
                        runes_in = clamp_n;
                     end
                     left_in  = clamp_n;
                     used_in  = '0;
                     rbl_in   = 2'd0;
                     phase_in = (clamp_n != '0) ? PH_LEAD : PH_NEWLINE;
                  end
               endcase
            end
         end
         PH_LEAD: begin
            if (used_ff >= TB_LIMIT) begin
               err_hit  = 1'b1;
               err_code = ERR_TOO_LONG;
            end else begin
               used_in = used_ff + 1'b1;
               emit    = 1'b1;
               if (!cmd.data[7]) begin
                  left_in  = left_dec;
                  phase_in = (left_dec != '0) ? PH_LEAD : PH_NEWLINE;
               end else begin
                  rbl_in   = (cmd.data < LEAD_THREE) ? 2'd1 :
                             (cmd.data < LEAD_FOUR)  ? 2'd2 : 2'd3;
                  phase_in = PH_CONT;
               end
            end
         end
         PH_CONT: begin
            used_in = used_ff + 1'b1;
            rbl_in  = rbl_dec;
            emit    = 1'b1;
            if (rbl_dec == 2'd0) begin
               left_in  = left_dec;
               phase_in = (left_dec != '0) ? PH_LEAD : PH_NEWLINE;
            end
         end
         PH_NEWLINE: begin
            if (!cmd.is_newline) begin
               err_hit  = 1'b1;
               err_code = ERR_NEWLINE;
            end else begin
               phase_in = PH_ORIGIN;
               if (rec_ff == REC_PRIMARY && flags_ff[1]) begin
                  rec_in = REC_EXPANSION;
               end else if ((rec_ff == REC_PRIMARY || rec_ff == REC_EXPANSION)
                            && flags_ff[3]) begin
                  rec_in = REC_DISCARD_A;
               end else if (rec_ff == REC_DISCARD_A) begin
                  rec_in = REC_DISCARD_B;
               end else begin
                  rec_in        = REC_PRIMARY;
                  has_rsp       = 1'b1;
                  rsp_base.kind = KIND_COMPLETE;
               end
            end
         end
         PH_SKIP: begin
            if (cmd.is_newline) begin
               phase_in = PH_ORIGIN;
               rec_in   = REC_PRIMARY;
            end
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      if (emit && (rec_ff == REC_PRIMARY || rec_ff == REC_EXPANSION)) begin
         has_rsp            = 1'b1;
         rsp_base.kind      = KIND_TEXT;
         rsp_base.text_byte = cmd.data;
         rsp_base.from_exp  = (rec_ff == REC_EXPANSION);
      end

      if (err_hit) begin
         phase_in      = cmd.is_newline ? PH_ORIGIN : PH_SKIP;
         rec_in        = REC_PRIMARY;
         has_rsp       = 1'b1;
         rsp_base.kind = KIND_ERROR;
         rsp_base.err  = err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ORIGIN;
         rec_ff       <= REC_PRIMARY;
         slot_ff      <= 2'd0;
         acc_ff       <= '0;
         origin_ff    <= '0;
         type_ff      <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         exp_start_ff <= '0;
         exp_end_ff   <= '0;
         flags_ff     <= '0;
         runes_ff     <= '0;
         left_ff      <= '0;
         rbl_ff       <= '0;
         used_ff      <= '0;
      end else if (cmd_take) begin
         phase_ff     <= phase_in;
         rec_ff       <= rec_in;
         slot_ff      <= slot_in;
         acc_ff       <= acc_in;
         origin_ff    <= origin_in;
         type_ff      <= type_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         exp_start_ff <= exp_start_in;
         exp_end_ff   <= exp_end_in;
         flags_ff     <= flags_in;
         runes_ff     <= runes_in;
         left_ff      <= left_in;
         rbl_ff       <= rbl_in;
         used_ff      <= used_in;
      end
   end

endmodule

`default_nettype wire

FILE: bench/erp_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erp_record_checker: result checker for the event record parser
// Follows every accepted byte with its own parser state, queues the results
// that byte must give, and compares each popped result field by field.
// ----------------------------------------------------------------------------

module erp_record_checker
   import erp_pkg::*;
#(
   parameter int MAX_RUNES  = MAX_RUNES_DEF,
   parameter int TEXT_BYTES = TEXT_BYTES_DEF,
   parameter int RUNE_W     = $clog2(MAX_RUNES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic [7:0]        req_in_byte,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [1:0]        rsp_result_kind,
   input  logic [7:0]        rsp_text_byte,
   input  logic              rsp_from_expansion,
   input  logic [7:0]        rsp_origin_char,
   input  logic [7:0]        rsp_type_char,
   input  logic [NUM_W-1:0]  rsp_start_pos,
   input  logic [NUM_W-1:0]  rsp_end_pos,
   input  logic [NUM_W-1:0]  rsp_expanded_start,
   input  logic [NUM_W-1:0]  rsp_expanded_end,
   input  logic [NUM_W-1:0]  rsp_flag_bits,
   input  logic [RUNE_W-1:0] rsp_rune_total,
   input  logic [1:0]        rsp_error_code,
   output int                fail_count,
   output int                pending,
   output int                text_seen,
   output int                done_seen,
   output int                error_seen,
   output logic [3:0]        codes_seen
);

   localparam logic [1:0] FIELD_START = 2'd0;
   localparam logic [1:0] FIELD_END   = 2'd1;
   localparam logic [1:0] FIELD_FLAGS = 2'd2;
   localparam logic [1:0] FIELD_RUNES = 2'd3;

   localparam int         FLAG_EXPAND  = 1;
   localparam int         FLAG_DISCARD = 3;
   localparam logic [7:0] LEAD_TWO     = 8'h80;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        text_byte;
      logic              from_exp;
      logic [7:0]        origin;
      logic [7:0]        type_char;
      logic [NUM_W-1:0]  start_pos;
      logic [NUM_W-1:0]  end_pos;
      logic [NUM_W-1:0]  exp_start;
      logic [NUM_W-1:0]  exp_end;
      logic [NUM_W-1:0]  flags;
      logic [RUNE_W-1:0] runes;
      err_type           err;
   } event_result_type;

   event_result_type pending_results[$];

   phase_type         phase;
   rec_type           rec;
   logic [1:0]        field;
   logic [31:0]       acc;
   logic [7:0]        held_origin;
   logic [7:0]        held_type;
   logic [NUM_W-1:0]  held_start;
   logic [NUM_W-1:0]  held_end;
   logic [NUM_W-1:0]  held_xstart;
   logic [NUM_W-1:0]  held_xend;
   logic [NUM_W-1:0]  held_flags;
   logic [RUNE_W-1:0] held_runes;
   logic [RUNE_W-1:0] runes_left;
   logic [1:0]        cont_left;
   int                text_used;

   task automatic clear_state();
      phase       = PH_ORIGIN;
      rec         = REC_PRIMARY;
      field       = FIELD_START;
      acc         = '0;
      held_origin = '0;
      held_type   = '0;
      held_start  = '0;
      held_end    = '0;
      held_xstart = '0;
      held_xend   = '0;
      held_flags  = '0;
      held_runes  = '0;
      runes_left  = '0;
      cont_left   = '0;
      text_used   = 0;
   endtask

   task automatic push_result(input kind_type k, input logic [7:0] t, input logic fx,
                              input err_type e);
      event_result_type r;
      r.kind      = k;
      r.text_byte = t;
      r.from_exp  = fx;
      r.origin    = held_origin;
      r.type_char = held_type;
      r.start_pos = held_start;
      r.end_pos   = held_end;
      r.exp_start = held_xstart;
      r.exp_end   = held_xend;
      r.flags     = held_flags;
      r.runes     = held_runes;
      r.err       = e;
      pending_results.push_back(r);
   endtask

   task automatic raise_error(input err_type e, input logic [7:0] b);
      phase = (b == CHAR_NEWLINE) ? PH_ORIGIN : PH_SKIP;
      rec   = REC_PRIMARY;
      push_result(KIND_ERROR, '0, 1'b0, e);
   endtask

   task automatic emit_text(input logic [7:0] b);
      if (rec == REC_PRIMARY || rec == REC_EXPANSION) begin
         push_result(KIND_TEXT, b, rec == REC_EXPANSION, ERR_TERMINATOR);
      end
   endtask

   task automatic end_rune();
      if (runes_left != 0) begin
         runes_left--;
      end
      phase = (runes_left != 0) ? PH_LEAD : PH_NEWLINE;
   endtask

   task automatic finish_number(input logic [NUM_W-1:0] value);
      logic [RUNE_W-1:0] clamped;
      case (field)
         FIELD_START: begin
            if (rec == REC_PRIMARY) begin
               held_start  = value;
               held_xstart = value;
            end else if (rec == REC_EXPANSION) begin
               held_xstart = value;
            end
         end
         FIELD_END: begin
            if (rec == REC_PRIMARY) begin
               held_end  = value;
               held_xend = value;
            end else if (rec == REC_EXPANSION) begin
               held_xend = value;
            end
         end
         FIELD_FLAGS: begin
            if (rec == REC_PRIMARY) begin
               held_flags = value;
            end
         end
         default: begin
            clamped = (value > MAX_RUNES) ? RUNE_W'(MAX_RUNES) : value[RUNE_W-1:0];
            if (rec == REC_PRIMARY) begin
               held_runes = clamped;
            end
            runes_left = clamped;
            text_used  = 0;
            cont_left  = '0;
            phase      = (clamped != 0) ? PH_LEAD : PH_NEWLINE;
         end
      endcase
      if (field != FIELD_RUNES) begin
         field++;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic [63:0] grown;
      case (phase)
         PH_ORIGIN: begin
            if (rec == REC_PRIMARY) begin
               held_origin = b;
            end
            phase = PH_TYPE;
         end
         PH_TYPE: begin
            if (rec == REC_PRIMARY) begin
               held_type = b;
            end
            acc   = '0;
            field = FIELD_START;
            phase = PH_NUM;
         end
         PH_NUM: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               grown = 64'(acc) * 64'd10 + 64'(b - CHAR_ZERO);
               if (grown > 64'(NUM_MAX)) begin
                  raise_error(ERR_OVERFLOW, b);
               end else begin
                  acc = grown[31:0];
               end
            end else if (b != CHAR_SPACE) begin
               raise_error(ERR_TERMINATOR, b);
            end else begin
               grown = 64'(acc);
               acc   = '0;
               finish_number(grown[NUM_W-1:0]);
            end
         end
         PH_LEAD: begin
            if (text_used >= TEXT_BYTES - 4) begin
               raise_error(ERR_TOO_LONG, b);
            end else begin
               text_used++;
               if (b < LEAD_TWO) begin
                  end_rune();
               end else begin
                  cont_left = (b < LEAD_THREE) ? 2'd1 : (b < LEAD_FOUR) ? 2'd2 : 2'd3;
                  phase     = PH_CONT;
               end
               emit_text(b);
            end
         end
         PH_CONT: begin
            text_used++;
            if (cont_left != 0) begin
               cont_left--;
            end
            if (cont_left == 0) begin
               end_rune();
            end
            emit_text(b);
         end
         PH_NEWLINE: begin
            if (b != CHAR_NEWLINE) begin
               raise_error(ERR_NEWLINE, b);
            end else begin
               phase = PH_ORIGIN;
               if (rec == REC_PRIMARY && held_flags[FLAG_EXPAND]) begin
                  rec = REC_EXPANSION;
               end else if ((rec == REC_PRIMARY || rec == REC_EXPANSION) &&
                            held_flags[FLAG_DISCARD]) begin
                  rec = REC_DISCARD_A;
               end else if (rec == REC_DISCARD_A) begin
                  rec = REC_DISCARD_B;
               end else begin
                  rec = REC_PRIMARY;
                  push_result(KIND_COMPLETE, '0, 1'b0, ERR_TERMINATOR);
               end
            end
         end
         default: begin
            if (b == CHAR_NEWLINE) begin
               phase = PH_ORIGIN;
               rec   = REC_PRIMARY;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      event_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result, actual kind %0d", $time, rsp_result_kind);
         fail_count++;
      end else begin
         want = pending_results.pop_front();
         check_field("result_kind", want.kind, rsp_result_kind);
         check_field("text_byte", want.text_byte, rsp_text_byte);
         check_field("from_expansion", want.from_exp, rsp_from_expansion);
         check_field("origin_char", want.origin, rsp_origin_char);
         check_field("type_char", want.type_char, rsp_type_char);
         check_field("start_pos", want.start_pos, rsp_start_pos);
         check_field("end_pos", want.end_pos, rsp_end_pos);
         check_field("expanded_start", want.exp_start, rsp_expanded_start);
         check_field("expanded_end", want.exp_end, rsp_expanded_end);
         check_field("flag_bits", want.flags, rsp_flag_bits);
         check_field("rune_total", want.runes, rsp_rune_total);
         check_field("error_code", want.err, rsp_error_code);
         case (want.kind)
            KIND_TEXT:     text_seen++;
            KIND_COMPLETE: done_seen++;
            default: begin
               error_seen++;
               codes_seen[want.err] = 1'b1;
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         pending_results.delete();
         fail_count = 0;
         text_seen  = 0;
         done_seen  = 0;
         error_seen = 0;
         codes_seen = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_result();
         end
         if (req_push && !req_full) begin
            parse_byte(req_in_byte);
         end
      end
      pending = pending_results.size();
   end

endmodule

FILE: bench/tb_editor_event_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_editor_event_record_parser: testbench of the event record parser
// Streams record groups (primary, expansion and discarded records, with
// random numbers, runes and injected damage) through the byte queue under
// bursty transfers and random result stalls; the checker does the scoring.
// ----------------------------------------------------------------------------

module tb_editor_event_record_parser;
   import erp_pkg::*;

   localparam int RUNE_W      = $clog2(MAX_RUNES_DEF + 1);
   localparam int CYCLE_LIMIT = 400000;
   // includes one long-text group of about 1050 bytes
   localparam int BYTE_TARGET = 1600;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_push    = 1'b0;
   logic [7:0]        req_in_byte = 8'h00;
   logic              rsp_pop     = 1'b0;
   logic              req_full;
   logic              rsp_empty;
   logic [1:0]        rsp_result_kind;
   logic [7:0]        rsp_text_byte;
   logic              rsp_from_expansion;
   logic [7:0]        rsp_origin_char;
   logic [7:0]        rsp_type_char;
   logic [NUM_W-1:0]  rsp_start_pos;
   logic [NUM_W-1:0]  rsp_end_pos;
   logic [NUM_W-1:0]  rsp_expanded_start;
   logic [NUM_W-1:0]  rsp_expanded_end;
   logic [NUM_W-1:0]  rsp_flag_bits;
   logic [RUNE_W-1:0] rsp_rune_total;
   logic [1:0]        rsp_error_code;

   int         fail_count;
   int         pending;
   int         text_seen;
   int         done_seen;
   int         error_seen;
   logic [3:0] codes_seen;

   int         cycle_count = 0;
   int         bytes_sent  = 0;
   int         groups_sent = 0;
   int         burst_left  = 0;
   bit         steady      = 1'b0;
   logic [7:0] group_bytes[$];

   initial begin
      forever #5 clock = ~clock;
   end

   editor_event_record_parser i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_in_byte        (req_in_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_text_byte      (rsp_text_byte),
      .rsp_from_expansion (rsp_from_expansion),
      .rsp_origin_char    (rsp_origin_char),
      .rsp_type_char      (rsp_type_char),
      .rsp_start_pos      (rsp_start_pos),
      .rsp_end_pos        (rsp_end_pos),
      .rsp_expanded_start (rsp_expanded_start),
      .rsp_expanded_end   (rsp_expanded_end),
      .rsp_flag_bits      (rsp_flag_bits),
      .rsp_rune_total     (rsp_rune_total),
      .rsp_error_code     (rsp_error_code)
   );

   erp_record_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_in_byte        (req_in_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_text_byte      (rsp_text_byte),
      .rsp_from_expansion (rsp_from_expansion),
      .rsp_origin_char    (rsp_origin_char),
      .rsp_type_char      (rsp_type_char),
      .rsp_start_pos      (rsp_start_pos),
      .rsp_end_pos        (rsp_end_pos),
      .rsp_expanded_start (rsp_expanded_start),
      .rsp_expanded_end   (rsp_expanded_end),
      .rsp_flag_bits      (rsp_flag_bits),
      .rsp_rune_total     (rsp_rune_total),
      .rsp_error_code     (rsp_error_code),
      .fail_count         (fail_count),
      .pending            (pending),
      .text_seen          (text_seen),
      .done_seen          (done_seen),
      .error_seen         (error_seen),
      .codes_seen         (codes_seen)
   );

   function automatic string pick_number(input bit allow_overflow);
      int sel;
      sel = $urandom_range(0, 99);
      if (allow_overflow && sel < 3) begin
         return ($urandom_range(0, 1) != 0) ? "2147483648" : "99999999999";
      end
      if (sel < 12) begin
         return "";
      end
      if (sel < 20) begin
         return $sformatf("00%0d", $urandom_range(0, 9));
      end
      if (sel < 27) begin
         return "2147483647";
      end
      if (sel < 45) begin
         return $sformatf("%0d", $urandom & 32'h7FFF_FFFF);
      end
      return $sformatf("%0d", $urandom_range(0, 999));
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         group_bytes.push_back(s[i]);
      end
   endtask

   // rune class: 0 single byte, 1..3 number of continuation bytes
   task automatic add_rune(input int cls);
      case (cls)
         0:       group_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
         1:       group_bytes.push_back(8'($urandom_range(8'h80, 8'hDF)));
         2:       group_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
         default: group_bytes.push_back(8'($urandom_range(8'hF0, 8'hFF)));
      endcase
      repeat (cls) begin
         group_bytes.push_back(8'($urandom));
      end
   endtask

   // long: 0 short text, 1 rune count above the clamp with four-byte runes
   task automatic add_record(input string flag_txt, input int long);
      string count_txt;
      int    runes;
      group_bytes.push_back(8'($urandom));
      group_bytes.push_back(8'($urandom));
      put_text({pick_number(1'b1), " "});
      put_text({pick_number(1'b1), " "});
      put_text({flag_txt, " "});
      if (long != 0) begin
         count_txt = "300";
      end else if ($urandom_range(0, 9) == 0) begin
         count_txt = "";
      end else begin
         count_txt = $sformatf("%0d", $urandom_range(1, 6));
      end
      runes = count_txt.atoi();
      if (runes > MAX_RUNES_DEF) begin
         runes = MAX_RUNES_DEF;
      end
      put_text({count_txt, " "});
      repeat (runes) begin
         add_rune((long != 0) ? 3 : $urandom_range(0, 3));
      end
      group_bytes.push_back(CHAR_NEWLINE);
   endtask

   task automatic build_group(input int long);
      logic [NUM_W-1:0] flag_val;
      string            flag_txt;
      int               pos;
      group_bytes.delete();
      flag_val    = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom) :
                                                  NUM_W'($urandom_range(0, 15));
      flag_val[1] = ($urandom_range(0, 2) == 0);
      flag_val[3] = ($urandom_range(0, 4) == 0);
      flag_txt    = (flag_val == 0 && $urandom_range(0, 1) != 0) ? "" :
                                                                  $sformatf("%0d", flag_val);
      add_record(flag_txt, long);
      if (flag_val[1]) begin
         add_record(pick_number(1'b0), 0);
      end
      if (flag_val[3]) begin
         add_record(pick_number(1'b0), 0);
         add_record(pick_number(1'b0), 0);
      end
      pos = $urandom_range(0, group_bytes.size() - 1);
      case ($urandom_range(0, 19))
         0, 1:    group_bytes[pos] = 8'($urandom);
         2:       group_bytes.insert(pos, 8'($urandom));
         3:       group_bytes.delete(group_bytes.size() - 1);
         default: ;
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = steady ? 0 : $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_push    <= 1'b0;
            req_in_byte <= 8'($urandom);
         end
      end
      burst_left--;
      @(negedge clock);
      req_push    <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_group();
      foreach (group_bytes[i]) begin
         send_byte(group_bytes[i]);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** editor_event_record_parser: FAILED **");
      $finish;
   end

   initial begin
      int seg;
      int mode;
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         seg  = $urandom_range(4, 40);
         mode = $urandom_range(0, 2);
         repeat (seg) begin
            @(negedge clock);
            case (mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               default: rsp_pop <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty numbers with newline as origin, an overflowing number, a bad terminator
      group_bytes.delete();
      group_bytes.push_back(CHAR_NEWLINE);
      group_bytes.push_back(8'hFF);
      put_text("    \n");
      put_text("ab2147483648\ncd1x\n");
      send_group();
      wait_drained();

      while (bytes_sent < BYTE_TARGET || groups_sent < 8) begin
         steady = ($urandom_range(0, 3) == 0);
         build_group((groups_sent == 2) ? 1 : 0);
         send_group();
         groups_sent++;
         if (groups_sent % 4 == 0) begin
            wait_drained();
         end
      end
      wait_drained();
      repeat (10) @(negedge clock);

      $display("Streamed %0d bytes in %0d record groups after a short directed prologue.",
               bytes_sent, groups_sent);
      $display("Checked %0d text bytes, %0d completed events, %0d parse errors (codes %b).",
               text_seen, done_seen, error_seen, codes_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("** editor_event_record_parser: PASSED **");
      end else begin
         $display("** editor_event_record_parser: FAILED **");
      end
      $finish;
   end

endmodule
